// ===== design/imia_pkg.sv =====
// Shared types, sizes and codes of the interval map id allocator.
// Used by imia_map_ram, imia_seq and interval_map_id_allocator.
// Depends on nothing else.
package imia_pkg;

    // Map storage size in boundary words.
    localparam int MAP_WORDS = 256;
    localparam int AW        = $clog2(MAP_WORDS);
    localparam int CW        = $clog2(MAP_WORDS + 1);
    localparam int ID_W      = 32;
    localparam int LIMIT_W   = 9;
    localparam int RW        = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

    typedef logic [AW-1:0]      addr_t;
    typedef logic [CW-1:0]      cnt_t;
    typedef logic [ID_W-1:0]    word_t;
    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [RW-1:0]      room_t;

    localparam word_t  U32_MAX     = {ID_W{1'b1}};
    localparam limit_t LIMIT_RESET = limit_t'(256);

    // Command codes carried on the input tuser bit.
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_EXHAUSTED    = 2'd1,
        ST_MAP_FULL     = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    typedef struct packed {
        word_t   granted_id;
        status_t status;
    } result_t;

    // One access to the boundary memory: an optional write and two reads.
    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        addr_t raddr_a;
        addr_t raddr_b;
    } mem_req_t;

endpackage

// ===== design/imia_map_ram.sv =====
// Boundary word memory: one write port, two read ports, registered read data.
// Depends on imia_pkg for sizes and the request struct.
module imia_map_ram (
    input  logic               clk,
    input  imia_pkg::mem_req_t req,
    output imia_pkg::word_t    rd_a,
    output imia_pkg::word_t    rd_b
);
    import imia_pkg::*;

    word_t mem [MAP_WORDS];

    // Write first in program order, reads return the old contents.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_a <= mem[req.raddr_a];
        rd_b <= mem[req.raddr_b];
    end

endmodule

// ===== design/imia_seq.sv =====
// Sequencer for the allocator: scans pairs, updates words and shifts the map
// tail by read-modify-write on the boundary memory. Depends on imia_pkg.
module imia_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_command,
    input  imia_pkg::word_t    in_object_id,
    input  imia_pkg::limit_t   map_limit,
    output logic               res_valid,
    input  logic               res_ready,
    output imia_pkg::result_t  res,
    output imia_pkg::mem_req_t mem_req,
    input  imia_pkg::word_t    rd_a,
    input  imia_pkg::word_t    rd_b,
    output imia_pkg::cnt_t     map_count
);
    import imia_pkg::*;

    typedef enum logic [11:0] {
        S_INIT0    = 12'b000000000001,
        S_INIT1    = 12'b000000000010,
        S_IDLE     = 12'b000000000100,
        S_ALLOC_EV = 12'b000000001000,
        S_REL_RD   = 12'b000000010000,
        S_REL_EV   = 12'b000000100000,
        S_SHDN     = 12'b000001000000,
        S_SHUP     = 12'b000010000000,
        S_SPL_GAP  = 12'b000100000000,
        S_SPL_LO   = 12'b001000000000,
        S_SPL_HI   = 12'b010000000000,
        S_RESP     = 12'b100000000000
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    cnt_t    idx_reg, idx_next;
    addr_t   dst_reg, dst_next;
    addr_t   last_reg, last_next;
    word_t   id_reg, id_next;
    logic    wpend_reg, wpend_next;
    addr_t   wpend_addr_reg, wpend_addr_next;
    result_t res_reg, res_next;

    cnt_t  idx_p1, idx_p2, idx_p3, count_m3, count_p1;
    room_t room, count_p2;
    logic  map_full;

    // Index arithmetic shared by the scan and the shift setup.
    assign idx_p1   = idx_reg + cnt_t'(1);
    assign idx_p2   = idx_reg + cnt_t'(2);
    assign idx_p3   = idx_reg + cnt_t'(3);
    assign count_m3 = count_reg - cnt_t'(3);
    assign count_p1 = count_reg + cnt_t'(1);

    // Room left for a split: the lesser of the limit and the memory size.
    assign room     = (room_t'(map_limit) > room_t'(MAP_WORDS)) ?
                      room_t'(MAP_WORDS) : room_t'(map_limit);
    assign count_p2 = room_t'(count_reg) + room_t'(2);
    assign map_full = count_p2 > room;

    assign res       = res_reg;
    assign map_count = count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        dst_next        = dst_reg;
        last_next       = last_reg;
        id_next         = id_reg;
        wpend_next      = 1'b0;
        wpend_addr_next = wpend_addr_reg;
        res_next        = res_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        mem_req         = '0;

        // A copy read in the previous cycle lands now.
        if (wpend_reg)
        begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wpend_addr_reg;
            mem_req.wdata = rd_a;
        end

        case (state_reg)
            S_INIT0:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = addr_t'(0);
                mem_req.wdata = word_t'(1);
                state_next    = S_INIT1;
            end

            S_INIT1:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = addr_t'(1);
                mem_req.wdata = word_t'(1);
                state_next    = S_IDLE;
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    id_next = in_object_id;
                    if (in_command == CMD_ALLOC)
                    begin
                        mem_req.raddr_a = addr_t'(1);
                        mem_req.raddr_b = addr_t'(2);
                        state_next      = S_ALLOC_EV;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_REL_RD;
                    end
                end
            end

            // Hand out the first free id, or report exhausted when it is U32_MAX, and
            // merge the first two runs if the first free run empties.
            S_ALLOC_EV:
            begin
                if (rd_a == U32_MAX)
                begin
                    res_next.granted_id = '0;
                    res_next.status     = ST_EXHAUSTED;
                    state_next          = S_RESP;
                end
                else
                begin
                    mem_req.we          = 1'b1;
                    mem_req.waddr       = addr_t'(1);
                    mem_req.wdata       = rd_a + word_t'(1);
                    res_next.granted_id = rd_a;
                    res_next.status     = ST_OK;
                    if ((count_reg > cnt_t'(2)) && ((rd_a + word_t'(1)) == rd_b))
                    begin
                        dst_next   = addr_t'(1);
                        last_next  = count_m3[AW-1:0];
                        count_next = count_reg - cnt_t'(2);
                        state_next = S_SHDN;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            // Fetch the next pair, or give up when the pairs run out.
            S_REL_RD:
            begin
                if (idx_p1 < count_reg)
                begin
                    mem_req.raddr_a = idx_reg[AW-1:0];
                    mem_req.raddr_b = idx_p1[AW-1:0];
                    state_next      = S_REL_EV;
                end
                else
                begin
                    res_next.granted_id = '0;
                    res_next.status     = ST_ALREADY_FREE;
                    state_next          = S_RESP;
                end
            end

            // Compare the released id against one pair.
            S_REL_EV:
            begin
                res_next.granted_id = '0;
                res_next.status     = ST_OK;
                if (id_reg == rd_a)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = idx_reg[AW-1:0];
                    mem_req.wdata = rd_a + word_t'(1);
                    state_next    = S_RESP;
                    if ((rd_a + word_t'(1)) == rd_b)
                    begin
                        count_next = count_reg - cnt_t'(2);
                        if (idx_p2 < count_reg)
                        begin
                            dst_next   = idx_reg[AW-1:0];
                            last_next  = count_m3[AW-1:0];
                            state_next = S_SHDN;
                        end
                    end
                end
                else if ((id_reg > rd_a) && (id_reg < rd_b))
                begin
                    if ((id_reg + word_t'(1)) == rd_b)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = idx_p1[AW-1:0];
                        mem_req.wdata = rd_b - word_t'(1);
                        state_next    = S_RESP;
                    end
                    else if (map_full)
                    begin
                        res_next.status = ST_MAP_FULL;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        dst_next   = count_p1[AW-1:0];
                        last_next  = idx_p3[AW-1:0];
                        count_next = count_reg + cnt_t'(2);
                        state_next = S_SHUP;
                    end
                end
                else
                begin
                    idx_next   = idx_p2;
                    state_next = S_REL_RD;
                end
            end

            // Move the tail down by two words, one word per cycle.
            S_SHDN:
            begin
                mem_req.raddr_a = dst_reg + addr_t'(2);
                wpend_next      = 1'b1;
                wpend_addr_next = dst_reg;
                if (dst_reg == last_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    dst_next = dst_reg + addr_t'(1);
                end
            end

            // Move the tail up by two words, highest word first.
            S_SHUP:
            begin
                mem_req.raddr_a = dst_reg - addr_t'(2);
                wpend_next      = 1'b1;
                wpend_addr_next = dst_reg;
                if (dst_reg == last_reg)
                begin
                    state_next = S_SPL_GAP;
                end
                else
                begin
                    dst_next = dst_reg - addr_t'(1);
                end
            end

            // The last tail copy uses the write port here.
            S_SPL_GAP:
            begin
                state_next = S_SPL_LO;
            end

            S_SPL_LO:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_p1[AW-1:0];
                mem_req.wdata = id_reg;
                state_next    = S_SPL_HI;
            end

            S_SPL_HI:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_p2[AW-1:0];
                mem_req.wdata = id_reg + word_t'(1);
                state_next    = S_RESP;
            end

            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT0;
            count_reg      <= cnt_t'(2);
            idx_reg        <= '0;
            dst_reg        <= '0;
            last_reg       <= '0;
            id_reg         <= '0;
            wpend_reg      <= 1'b0;
            wpend_addr_reg <= '0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            dst_reg        <= dst_next;
            last_reg       <= last_next;
            id_reg         <= id_next;
            wpend_reg      <= wpend_next;
            wpend_addr_reg <= wpend_addr_next;
            res_reg        <= res_next;
        end
    end

endmodule

// ===== design/interval_map_id_allocator.sv =====
// Top level of the interval map id allocator: configuration register,
// output register, sequencer and boundary memory. Depends on imia_pkg,
// imia_map_ram and imia_seq.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata object_id, tuser command
//  m_axis   | out       | m_axis_tvalid/tready    | tdata granted_id, tuser status
//  cfg      | in        | cfg_valid/cfg_ready     | cfg_data map_limit
//
// One request is worked at a time. An allocate reads the first pair and copies
// the tail down when the first two used runs merge. A release checks one pair
// after another, copies the tail when a pair goes or a run splits, and for a
// split then writes the two new boundaries; all writes share the single write port.
// After reset, S_INIT0 and S_INIT1 load the initial map before s_axis_tready rises.
// A result waits in the output register while the next request is taken in.
module interval_map_id_allocator (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [31:0]              s_axis_tdata,  // [31:0] object_id
    input  logic [0:0]               s_axis_tuser,  // [0] command
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [31:0]              m_axis_tdata,  // [31:0] granted_id
    output logic [1:0]               m_axis_tuser,  // [1:0] status
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  imia_pkg::limit_t         cfg_data
);
    import imia_pkg::*;

    limit_t   map_limit_reg;
    logic     out_valid_reg;
    result_t  out_data_reg;
    logic     res_valid, res_ready;
    result_t  res;
    mem_req_t mem_req;
    word_t    rd_a, rd_b;
    cnt_t     map_count;

    // Map limit register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            map_limit_reg <= cfg_data;
        end
    end

    // Output register: loads a result when empty or being drained.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                out_data_reg <= res;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg.granted_id;
    assign m_axis_tuser  = out_data_reg.status;

    imia_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_command   (s_axis_tuser[0]),
        .in_object_id (s_axis_tdata),
        .map_limit    (map_limit_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_req      (mem_req),
        .rd_a         (rd_a),
        .rd_b         (rd_b),
        .map_count    (map_count)
    );

    imia_map_ram u_ram (
        .clk  (clk),
        .req  (mem_req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    // The map always holds whole pairs.
    a_count_even: assert property (@(posedge clk) disable iff (!rst_n)
        map_count[0] == 1'b0)
        else $error("map count is odd");

    // The map never outgrows the memory.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        map_count <= cnt_t'(MAP_WORDS))
        else $error("map count beyond memory size");

    // The count moves by exactly one pair at a time.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (map_count != $past(map_count)) |->
        ((map_count == $past(map_count) + cnt_t'(2)) ||
         (map_count == $past(map_count) - cnt_t'(2))))
        else $error("map count jumped");

    // Only one request is in work at a time.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while busy");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for interval_map_id_allocator: directed table, then random
// allocate and release traffic checked against an in-bench model of the boundary map.
// Depends on imia_pkg and the interval_map_id_allocator RTL.
module tb;
    import imia_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PHASE_ITEMS  = 45;
    localparam int DRAIN_CAP    = 500;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_LIMITS [NUM_PHASES] = '{256, 8, 2, 511, 37, 0, 256};

    // One line of the directed table: a request or a register write.
    typedef struct packed {
        logic    is_cfg;
        logic    cmd;
        word_t   arg;
        logic    typed;
        word_t   want_id;
        status_t want_st;
    } step_row_t;

    localparam int NUM_ROWS = 25;
    localparam step_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{1'b0, CMD_ALLOC,   32'd0,   1'b1, 32'd1, ST_OK},
        '{1'b0, CMD_ALLOC,   32'd0,   1'b1, 32'd2, ST_OK},
        '{1'b0, CMD_ALLOC,   32'd0,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_ALLOC,   32'd0,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_ALLOC,   32'd0,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_ALLOC,   32'd0,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_ALLOC,   32'd0,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_ALLOC,   32'd0,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_RELEASE, 32'd0,   1'b1, 32'd0, ST_ALREADY_FREE},
        '{1'b0, CMD_RELEASE, U32_MAX, 1'b1, 32'd0, ST_ALREADY_FREE},
        '{1'b0, CMD_RELEASE, 32'd9,   1'b1, 32'd0, ST_ALREADY_FREE},
        '{1'b0, CMD_RELEASE, 32'd4,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_ALLOC,   32'd0,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_RELEASE, 32'd8,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_RELEASE, 32'd1,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_RELEASE, 32'd5,   1'b0, 32'd0, ST_OK},
        '{1'b1, CMD_ALLOC,   32'd4,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_RELEASE, 32'd3,   1'b1, 32'd0, ST_MAP_FULL},
        '{1'b1, CMD_ALLOC,   32'd3,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_RELEASE, 32'd6,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_RELEASE, 32'd2,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_RELEASE, 32'd3,   1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_RELEASE, 32'd4,   1'b0, 32'd0, ST_OK},
        '{1'b1, CMD_ALLOC,   32'd511, 1'b0, 32'd0, ST_OK},
        '{1'b0, CMD_ALLOC,   32'd0,   1'b0, 32'd0, ST_OK}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] object_id
    logic [0:0]  s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] granted_id
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        cfg_valid;
    logic        cfg_ready;
    limit_t      cfg_data;

    // Model of the boundary map, its word count and the limit register.
    word_t   shadow_bounds [MAP_WORDS];
    int      shadow_count;
    limit_t  shadow_limit;

    result_t expected_grants [$];
    int      fail_count;
    int      cycle_count;
    int      stall_left;
    bit      idle_on;

    interval_map_id_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Updates the map model for one accepted request and returns its result.
    function automatic result_t apply_request(input logic cmd, input word_t id);
        result_t res;
        word_t   lo;
        word_t   hi;
        word_t   first_free;
        int      room;
        res.granted_id = '0;
        res.status     = ST_ALREADY_FREE;
        if (cmd == CMD_ALLOC)
        begin
            first_free = shadow_bounds[1];
            if (first_free == U32_MAX)
            begin
                res.status = ST_EXHAUSTED;
                return res;
            end
            shadow_bounds[1] = first_free + 1;
            // A one-id free run is used up: the first two used runs merge.
            if (shadow_count > 2 && shadow_bounds[1] == shadow_bounds[2])
            begin
                for (int j = 1; j <= shadow_count - 3; j++)
                    shadow_bounds[j] = shadow_bounds[j + 2];
                shadow_count -= 2;
            end
            res.granted_id = first_free;
            res.status     = ST_OK;
            return res;
        end
        room = (shadow_limit > MAP_WORDS) ? MAP_WORDS : int'(shadow_limit);
        for (int i = 0; i + 1 < shadow_count; i += 2)
        begin
            lo = shadow_bounds[i];
            hi = shadow_bounds[i + 1];
            // Releasing the start of a run; an emptied pair is removed.
            if (id == lo)
            begin
                shadow_bounds[i] = lo + 1;
                if (shadow_bounds[i] == hi)
                begin
                    for (int j = i; j + 2 < shadow_count; j++)
                        shadow_bounds[j] = shadow_bounds[j + 2];
                    shadow_count -= 2;
                end
                res.status = ST_OK;
                return res;
            end
            if (id > lo && id < hi)
            begin
                if (id + 1 == hi)
                begin
                    shadow_bounds[i + 1] = hi - 1;
                    res.status = ST_OK;
                end
                else if (shadow_count + 2 > room)
                    res.status = ST_MAP_FULL;
                else
                begin
                    // Split the run: the tail moves up by one pair.
                    for (int j = shadow_count - 1; j >= i + 1; j--)
                        shadow_bounds[j + 2] = shadow_bounds[j];
                    shadow_bounds[i + 1] = id;
                    shadow_bounds[i + 2] = id + 1;
                    shadow_count += 2;
                    res.status = ST_OK;
                end
                return res;
            end
        end
        return res;
    endfunction

    // Picks an id inside a random used run, favoring its two ends.
    function automatic word_t pick_used_id();
        int    pair;
        word_t lo;
        word_t hi;
        pair = $urandom_range(0, shadow_count / 2 - 1);
        lo   = shadow_bounds[2 * pair];
        hi   = shadow_bounds[2 * pair + 1];
        if (lo >= hi)
            return lo;
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi - 1;
            default: return lo + word_t'($urandom % (hi - lo));
        endcase
    endfunction

    // Mostly allocations and releases of ids in use, with some stray releases.
    task automatic pick_request(output logic cmd, output word_t id);
        int roll;
        roll = $urandom_range(0, 99);
        cmd  = CMD_RELEASE;
        id   = '0;
        if (shadow_count < 2 || (shadow_count == 2 && shadow_bounds[1] - shadow_bounds[0] < 3)
            || roll < 45)
            cmd = CMD_ALLOC;
        else if (roll < 85)
            id = pick_used_id();
        else
        begin
            case ($urandom_range(0, 3))
                0: id = $urandom;
                1: id = shadow_bounds[shadow_count - 1] + $urandom_range(0, 20);
                2: id = shadow_bounds[2 * $urandom_range(0, shadow_count / 2 - 1) + 1];
                default: id = $urandom_range(0, 1) ? U32_MAX : word_t'(0);
            endcase
        end
    endtask

    // Sends one request; an optional gap precedes it while idling is on.
    task automatic push_request(input logic cmd, input word_t id, input logic typed,
                                input result_t typed_res);
        result_t res;
        if (idle_on && $urandom_range(0, 99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= id;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = apply_request(cmd, id);
        if (typed)
            res = typed_res;
        expected_grants.push_back(res);
    endtask

    // Holds off new requests until every pending result has come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the map limit while the block is idle.
    task automatic write_limit(input limit_t value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        shadow_limit = value;
    endtask

    // Result side: random stall bursts of random length while idling is on.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 99) < 15)
        begin
            stall_left    <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compares each returned result with the oldest pending one.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_grants.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: granted_id %h status %0d",
                             m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = expected_grants.pop_front();
                if (m_axis_tdata !== want.granted_id || m_axis_tuser !== 2'(want.status))
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: granted_id exp %h got %h, status exp %0d got %0d",
                                 want.granted_id, m_axis_tdata, want.status, m_axis_tuser);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus: reset, directed table, random phases, then a drain of the map and requests on the empty map.
    initial
    begin
        logic    cmd;
        word_t   id;
        int      drained;
        result_t typed_res;
        result_t no_res;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_ALLOC;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= LIMIT_RESET;
        no_res        = '0;
        fail_count    = 0;
        cycle_count   = 0;
        stall_left    = 0;
        idle_on       = 1'b1;
        foreach (shadow_bounds[k])
            shadow_bounds[k] = '0;
        shadow_bounds[0] = 1;
        shadow_bounds[1] = 1;
        shadow_count     = 2;
        shadow_limit     = LIMIT_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        foreach (DIRECTED_ROWS[r])
        begin
            if (DIRECTED_ROWS[r].is_cfg)
                write_limit(limit_t'(DIRECTED_ROWS[r].arg));
            else
            begin
                typed_res.granted_id = DIRECTED_ROWS[r].want_id;
                typed_res.status     = DIRECTED_ROWS[r].want_st;
                push_request(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].arg,
                             DIRECTED_ROWS[r].typed, typed_res);
            end
        end

        // Random phases, each under its own map limit.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_limit(limit_t'(PHASE_LIMITS[p]));
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS)
            begin
                pick_request(cmd, id);
                push_request(cmd, id, 1'b0, no_res);
            end
        end

        // Release every id in use, then work on the empty map; no idling here.
        settle();
        idle_on = 1'b0;
        drained = 0;
        while (shadow_count > 0 && drained < DRAIN_CAP)
        begin
            id = $urandom_range(0, 1) ? shadow_bounds[0] : pick_used_id();
            push_request(CMD_RELEASE, id, 1'b0, no_res);
            drained++;
        end
        for (int k = 0; k < 6; k++)
        begin
            if (k % 2 == 0)
                push_request(CMD_ALLOC, '0, 1'b0, no_res);
            else
                push_request(CMD_RELEASE, shadow_bounds[1] - 1, 1'b0, no_res);
        end

        settle();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && expected_grants.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
